// ===== sv/suffix_automaton_substring_histogram_unit_assert.svh =====
// Assertion macros shared by the checker of the substring histogram unit.
`ifndef SUFFIX_AUTOMATON_SUBSTRING_HISTOGRAM_UNIT_ASSERT_SVH
`define SUFFIX_AUTOMATON_SUBSTRING_HISTOGRAM_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SASU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SASU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/sasu_pkg.sv =====
// Types and constants of the suffix automaton substring histogram unit.
package sasu_pkg;

    localparam int MAX_TEXT    = 4096;
    localparam int ALPHABET    = 26;

    localparam int SYMF_W      = 5;
    localparam int QLEN_W      = 13;
    localparam int CNT_W       = 13;
    localparam int HIST_W      = 14;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [22:0] {
        ST_CLRH  = 23'h000001,
        ST_IDLE  = 23'h000002,
        ST_A_LEN = 23'h000004,
        ST_A_CLR = 23'h000008,
        ST_W_RD  = 23'h000010,
        ST_W_CHK = 23'h000020,
        ST_H_LP  = 23'h000040,
        ST_H_LQ  = 23'h000080,
        ST_H_CMP = 23'h000100,
        ST_H_LNK = 23'h000200,
        ST_C_RD  = 23'h000400,
        ST_C_WR  = 23'h000800,
        ST_R_RD  = 23'h001000,
        ST_R_CHK = 23'h002000,
        ST_F_Q   = 23'h004000,
        ST_F_CUR = 23'h008000,
        ST_S_RD  = 23'h010000,
        ST_S_LO  = 23'h020000,
        ST_S_HI  = 23'h040000,
        ST_S_END = 23'h080000,
        ST_Q_RD  = 23'h100000,
        ST_Q_ADD = 23'h200000,
        ST_Q_OUT = 23'h400000
    } t_op;

    typedef struct packed {
        t_op  op;
        logic take;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic sym_ok;
        logic q_ok;
        logic tr_zero;
        logic tr_is_q;
        logic p_root;
        logic len_match;
        logic j_last;
        logic i_last;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/sasu_ctrl.sv =====
// Sequencing state machine of the suffix automaton substring histogram unit.
module sasu_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_action,
    input  sasu_pkg::t_stat i_stat,
    output sasu_pkg::t_cmd  o_cmd,
    output logic            o_ready
);

    sasu_pkg::t_op r_state, n_state;

    assign o_ready    = (r_state == sasu_pkg::ST_IDLE);
    assign o_cmd.op   = r_state;
    assign o_cmd.take = o_ready && i_s_tvalid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sasu_pkg::ST_CLRH: begin
                if (i_stat.clr_last) n_state = sasu_pkg::ST_IDLE;
            end
            sasu_pkg::ST_IDLE: begin
                if (o_cmd.take) begin
                    if (i_action == sasu_pkg::ACT_QUERY) begin
                        n_state = i_stat.q_ok ? sasu_pkg::ST_Q_RD : sasu_pkg::ST_Q_OUT;
                    end else if (!i_stat.full && i_stat.sym_ok) begin
                        n_state = sasu_pkg::ST_A_LEN;
                    end
                end
            end
            sasu_pkg::ST_A_LEN: n_state = sasu_pkg::ST_A_CLR;
            sasu_pkg::ST_A_CLR: begin
                if (i_stat.j_last) n_state = sasu_pkg::ST_W_RD;
            end
            sasu_pkg::ST_W_RD: n_state = sasu_pkg::ST_W_CHK;
            sasu_pkg::ST_W_CHK: begin
                if (!i_stat.tr_zero) n_state = sasu_pkg::ST_H_LP;
                else if (i_stat.p_root) n_state = sasu_pkg::ST_S_RD;
                else n_state = sasu_pkg::ST_W_RD;
            end
            sasu_pkg::ST_H_LP: n_state = sasu_pkg::ST_H_LQ;
            sasu_pkg::ST_H_LQ: n_state = sasu_pkg::ST_H_CMP;
            sasu_pkg::ST_H_CMP: begin
                n_state = i_stat.len_match ? sasu_pkg::ST_S_RD : sasu_pkg::ST_H_LNK;
            end
            sasu_pkg::ST_H_LNK: n_state = sasu_pkg::ST_C_RD;
            sasu_pkg::ST_C_RD:  n_state = sasu_pkg::ST_C_WR;
            sasu_pkg::ST_C_WR: begin
                n_state = i_stat.j_last ? sasu_pkg::ST_R_RD : sasu_pkg::ST_C_RD;
            end
            sasu_pkg::ST_R_RD: n_state = sasu_pkg::ST_R_CHK;
            sasu_pkg::ST_R_CHK: begin
                if (!i_stat.tr_is_q || i_stat.p_root) n_state = sasu_pkg::ST_F_Q;
                else n_state = sasu_pkg::ST_R_RD;
            end
            sasu_pkg::ST_F_Q:   n_state = sasu_pkg::ST_F_CUR;
            sasu_pkg::ST_F_CUR: n_state = sasu_pkg::ST_S_RD;
            sasu_pkg::ST_S_RD:  n_state = sasu_pkg::ST_S_LO;
            sasu_pkg::ST_S_LO:  n_state = sasu_pkg::ST_S_HI;
            sasu_pkg::ST_S_HI:  n_state = sasu_pkg::ST_S_END;
            sasu_pkg::ST_S_END: n_state = sasu_pkg::ST_IDLE;
            sasu_pkg::ST_Q_RD:  n_state = sasu_pkg::ST_Q_ADD;
            sasu_pkg::ST_Q_ADD: begin
                n_state = i_stat.i_last ? sasu_pkg::ST_Q_OUT : sasu_pkg::ST_Q_RD;
            end
            sasu_pkg::ST_Q_OUT: begin
                if (i_stat.out_free) n_state = sasu_pkg::ST_IDLE;
            end
            default: n_state = sasu_pkg::ST_CLRH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sasu_pkg::ST_CLRH;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/sasu_dp.sv =====
// Datapath of the substring histogram unit: automaton memories, histogram and result register.
module sasu_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sasu_pkg::t_cmd                     i_cmd,
    input  logic                               i_action,
    input  logic [sasu_pkg::SYMF_W-1:0]        i_symbol,
    input  logic [sasu_pkg::QLEN_W-1:0]        i_query_length,
    input  logic                               i_m_tready,
    output sasu_pkg::t_stat                    o_stat,
    output logic                               o_m_tvalid,
    output logic [sasu_pkg::CNT_W-1:0]         o_distinct_count,
    output logic                               o_overflow_seen
);

    localparam int MAX_TEXT = sasu_pkg::MAX_TEXT;
    localparam int ALPHABET = sasu_pkg::ALPHABET;
    localparam int LEN_W   = $clog2(MAX_TEXT + 1);
    localparam int NSTATES = 2 * MAX_TEXT;
    localparam int ST_W    = $clog2(NSTATES);
    localparam int SYM_W   = $clog2(ALPHABET);
    localparam int TR_AW   = ST_W + SYM_W;
    localparam int HDEPTH  = MAX_TEXT + 2;
    localparam int HIX_W   = $clog2(HDEPTH);
    localparam int CMP_W   = (LEN_W > sasu_pkg::QLEN_W) ? LEN_W : sasu_pkg::QLEN_W;
    localparam int HW      = sasu_pkg::HIST_W;

    logic [LEN_W-1:0] len_mem  [NSTATES];
    logic [ST_W-1:0]  link_mem [NSTATES];
    logic [ST_W-1:0]  tr_mem   [NSTATES << SYM_W];
    logic [HW-1:0]    hist_mem [HDEPTH];

    // Control state.
    logic [ST_W-1:0]  r_count, r_last;
    logic [LEN_W-1:0] r_text;
    logic             r_ovf;
    logic             r_out_valid;
    logic [HIX_W-1:0] r_clr;

    // Working registers.
    logic [ST_W-1:0]  r_p, r_cur, r_q, r_cl, r_lcur;
    logic [SYM_W-1:0] r_c, r_j;
    logic [LEN_W-1:0] r_len_cur, r_lenp;
    logic [HIX_W-1:0] r_k, r_i, r_lo;
    logic [HW-1:0]    r_sum;
    logic [sasu_pkg::CNT_W-1:0] r_out_cnt;
    logic             r_out_ovf;

    // Registered read data.
    logic [LEN_W-1:0] r_len_rd;
    logic             r_len_zero;
    logic [ST_W-1:0]  r_link_rd, r_tr_rd;
    logic [HW-1:0]    r_hist_rd;

    // Memory port controls.
    logic [ST_W-1:0]  len_ra, len_wa, link_ra, link_wa;
    logic [LEN_W-1:0] len_wd;
    logic [ST_W-1:0]  link_wd, tr_wd;
    logic [TR_AW-1:0] tr_ra, tr_wa;
    logic [HIX_W-1:0] hist_ra, hist_wa;
    logic [HW-1:0]    hist_wd;
    logic             len_we, link_we, tr_we, hist_we;

    logic [LEN_W-1:0] len_val;
    logic [CMP_W-1:0] k_ext, t_ext;
    logic [HIX_W-1:0] lo_idx, hi_idx;
    sasu_pkg::t_op    op;

    assign op      = i_cmd.op;
    // The root is never written: its length reads as zero.
    assign len_val = r_len_zero ? '0 : r_len_rd;
    assign k_ext   = CMP_W'(i_query_length);
    assign t_ext   = CMP_W'(r_text);
    assign lo_idx  = HIX_W'(len_val) + HIX_W'(1);
    assign hi_idx  = HIX_W'(r_len_cur) + HIX_W'(1);

    assign o_stat.full      = (r_text == LEN_W'(MAX_TEXT));
    assign o_stat.sym_ok    = (32'(i_symbol) < ALPHABET);
    assign o_stat.q_ok      = (i_query_length != '0) && (k_ext <= t_ext);
    assign o_stat.tr_zero   = (r_tr_rd == '0);
    assign o_stat.tr_is_q   = (r_tr_rd == r_q);
    assign o_stat.p_root    = (r_p == '0);
    assign o_stat.len_match = ((r_lenp + LEN_W'(1)) == len_val);
    assign o_stat.j_last    = (r_j == SYM_W'(ALPHABET - 1));
    assign o_stat.i_last    = (r_i == r_k);
    assign o_stat.clr_last  = (r_clr == HIX_W'(HDEPTH - 1));
    assign o_stat.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid       = r_out_valid;
    assign o_distinct_count = r_out_cnt;
    assign o_overflow_seen  = r_out_ovf;

    always_comb begin
        len_ra  = r_last;
        len_we  = 1'b0;
        len_wa  = r_count;
        len_wd  = r_len_rd + LEN_W'(1);
        link_ra = r_p;
        link_we = 1'b0;
        link_wa = r_count;
        link_wd = '0;
        tr_ra   = {r_p, r_c};
        tr_we   = 1'b0;
        tr_wa   = {r_p, r_c};
        tr_wd   = r_cur;
        hist_ra = r_i;
        hist_we = 1'b0;
        hist_wa = r_clr;
        hist_wd = '0;
        unique case (op)
            sasu_pkg::ST_CLRH: begin
                hist_we = 1'b1;
                // The root's transition row is cleared during the same pass.
                if (32'(r_clr) < ALPHABET) begin
                    tr_we = 1'b1;
                    tr_wa = {ST_W'(0), SYM_W'(r_clr)};
                    tr_wd = '0;
                end
            end
            sasu_pkg::ST_A_LEN: begin
                len_we  = 1'b1;
                len_wd  = len_val + LEN_W'(1);
                link_we = 1'b1;
            end
            sasu_pkg::ST_A_CLR: begin
                tr_we = 1'b1;
                tr_wa = {r_cur, r_j};
                tr_wd = '0;
            end
            sasu_pkg::ST_W_CHK: tr_we = o_stat.tr_zero;
            sasu_pkg::ST_H_LP:  len_ra = r_p;
            sasu_pkg::ST_H_LQ:  len_ra = r_q;
            sasu_pkg::ST_H_CMP: begin
                link_ra = r_q;
                if (o_stat.len_match) begin
                    link_we = 1'b1;
                    link_wa = r_cur;
                    link_wd = r_q;
                end else begin
                    len_we = 1'b1;
                    len_wd = r_lenp + LEN_W'(1);
                end
            end
            sasu_pkg::ST_H_LNK: begin
                link_we = 1'b1;
                link_wa = r_cl;
                link_wd = r_link_rd;
            end
            sasu_pkg::ST_C_RD: tr_ra = {r_q, r_j};
            sasu_pkg::ST_C_WR: begin
                tr_we = 1'b1;
                tr_wa = {r_cl, r_j};
                tr_wd = r_tr_rd;
            end
            sasu_pkg::ST_R_CHK: begin
                tr_we = o_stat.tr_is_q;
                tr_wd = r_cl;
            end
            sasu_pkg::ST_F_Q: begin
                link_we = 1'b1;
                link_wa = r_q;
                link_wd = r_cl;
            end
            sasu_pkg::ST_F_CUR: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_cl;
            end
            sasu_pkg::ST_S_RD: len_ra = r_lcur;
            sasu_pkg::ST_S_LO: hist_ra = lo_idx;
            sasu_pkg::ST_S_HI: begin
                hist_we = 1'b1;
                hist_wa = r_lo;
                hist_wd = r_hist_rd + HW'(1);
                hist_ra = hi_idx;
            end
            sasu_pkg::ST_S_END: begin
                hist_we = 1'b1;
                hist_wa = hi_idx;
                hist_wd = r_hist_rd - HW'(1);
            end
            default: begin
                len_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (len_we) len_mem[len_wa] <= len_wd;
        r_len_rd   <= len_mem[len_ra];
        r_len_zero <= (len_ra == '0);
    end

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        r_link_rd <= link_mem[link_ra];
    end

    always_ff @(posedge i_clk) begin
        if (tr_we) tr_mem[tr_wa] <= tr_wd;
        r_tr_rd <= tr_mem[tr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) hist_mem[hist_wa] <= hist_wd;
        r_hist_rd <= hist_mem[hist_ra];
    end

    // Working registers need no reset.
    always_ff @(posedge i_clk) begin
        unique case (op)
            sasu_pkg::ST_IDLE: begin
                if (i_cmd.take) begin
                    r_c   <= SYM_W'(i_symbol);
                    r_k   <= HIX_W'(i_query_length);
                    r_p   <= r_last;
                    r_i   <= '0;
                    r_sum <= '0;
                end
            end
            sasu_pkg::ST_A_LEN: begin
                r_cur     <= r_count;
                r_len_cur <= len_val + LEN_W'(1);
                r_lcur    <= '0;
                r_j       <= '0;
            end
            sasu_pkg::ST_A_CLR: r_j <= r_j + SYM_W'(1);
            sasu_pkg::ST_W_CHK: begin
                if (!o_stat.tr_zero) r_q <= r_tr_rd;
                else r_p <= r_link_rd;
            end
            sasu_pkg::ST_H_LQ: r_lenp <= len_val;
            sasu_pkg::ST_H_CMP: begin
                r_j <= '0;
                if (o_stat.len_match) begin
                    r_lcur <= r_q;
                end else begin
                    r_cl   <= r_count;
                    r_lcur <= r_count;
                end
            end
            sasu_pkg::ST_C_WR:  r_j <= r_j + SYM_W'(1);
            sasu_pkg::ST_R_CHK: r_p <= r_link_rd;
            sasu_pkg::ST_S_LO:  r_lo <= lo_idx;
            sasu_pkg::ST_Q_ADD: begin
                r_sum <= r_sum + r_hist_rd;
                r_i   <= r_i + HIX_W'(1);
            end
            sasu_pkg::ST_Q_OUT: begin
                if (o_stat.out_free) begin
                    r_out_cnt <= r_sum[sasu_pkg::CNT_W-1:0];
                    r_out_ovf <= r_ovf;
                end
            end
            default: begin
                r_lo <= r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= ST_W'(1);
            r_last      <= '0;
            r_text      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (op == sasu_pkg::ST_CLRH) r_clr <= r_clr + HIX_W'(1);
            if (i_cmd.take && i_action == sasu_pkg::ACT_APPEND && o_stat.full) begin
                r_ovf <= 1'b1;
            end
            if (op == sasu_pkg::ST_A_LEN) r_count <= r_count + ST_W'(1);
            if (op == sasu_pkg::ST_H_CMP && !o_stat.len_match) begin
                r_count <= r_count + ST_W'(1);
            end
            if (op == sasu_pkg::ST_S_END) begin
                r_last <= r_cur;
                r_text <= r_text + LEN_W'(1);
            end
            if (op == sasu_pkg::ST_Q_OUT && o_stat.out_free) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== sv/suffix_automaton_substring_histogram_unit.sv =====
// Top level of the suffix automaton substring histogram unit.
// After reset the histogram and the root's transitions are cleared, one entry a cycle, and
// no transaction is accepted until that is done. An append writes the new state, clears its
// transition row and walks the suffix links, reading and checking each state visited; when
// the walk meets a transition it loads and compares the two lengths, and a clone further
// sets its link, copies the row of q and redirects each transition to q while walking on.
// The row clear and the row copy of the transition memory take most of an append's time. An
// append that is ignored, at capacity or with a symbol outside the alphabet, leaves the unit
// idle and ready. A query for length k does one histogram read and one add per entry from 0
// to k; zero or out-of-range lengths go straight to the output step, and either is
// stretched while an earlier output transaction is still held. Appends produce no output;
// every query produces one output transaction.
module suffix_automaton_substring_histogram_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [sasu_pkg::IN_TDATA_W-1:0]      i_s_tdata,  // symbol[4:0], query_length[17:5]
    input  logic                                 i_s_tuser,  // action
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [sasu_pkg::OUT_TDATA_W-1:0]     o_m_tdata   // distinct_count[12:0], overflow_seen[13]
);

    sasu_pkg::t_cmd  cmd;
    sasu_pkg::t_stat stat;
    logic [sasu_pkg::CNT_W-1:0] distinct_count;
    logic                       overflow_seen;

    sasu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_ready    (o_s_tready)
    );

    sasu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_action         (i_s_tuser),
        .i_symbol         (i_s_tdata[sasu_pkg::SYMF_W-1:0]),
        .i_query_length   (i_s_tdata[sasu_pkg::SYMF_W+sasu_pkg::QLEN_W-1:sasu_pkg::SYMF_W]),
        .i_m_tready       (i_m_tready),
        .o_stat           (stat),
        .o_m_tvalid       (o_m_tvalid),
        .o_distinct_count (distinct_count),
        .o_overflow_seen  (overflow_seen)
    );

    assign o_m_tdata = {{(sasu_pkg::OUT_TDATA_W - sasu_pkg::CNT_W - 1){1'b0}},
                        overflow_seen, distinct_count};

endmodule

// ===== sv/sasu_checker.sv =====
// Port-level checker of the substring histogram unit and its binding.
`include "suffix_automaton_substring_histogram_unit_assert.svh"

module sasu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             i_s_tready,
    input logic                             i_s_tuser,
    input logic                             i_m_tvalid,
    input logic                             i_m_tready,
    input logic [sasu_pkg::OUT_TDATA_W-1:0] i_m_tdata
);

    logic r_ovf_seen;

    // Remembers that an output transaction has already reported overflow.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_seen <= 1'b0;
        end else if (i_m_tvalid && i_m_tready && i_m_tdata[sasu_pkg::CNT_W]) begin
            r_ovf_seen <= 1'b1;
        end
    end

    `SASU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata))
    `SASU_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tuser, !i_s_tready)
    `SASU_ASSERT_NOW(a_ovf_sticky, i_clk, i_rst_n, i_m_tvalid && r_ovf_seen, i_m_tdata[sasu_pkg::CNT_W])

endmodule

bind suffix_automaton_substring_histogram_unit sasu_checker u_sasu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata)
);

// ===== sim/suffix_automaton_substring_histogram_unit_tb.sv =====
// Self-checking testbench for the suffix automaton substring histogram unit.
module suffix_automaton_substring_histogram_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_CAP = 4096;
    localparam int LETTERS  = 26;
    localparam int STATE_CAP = 2 * TEXT_CAP;

    typedef struct {
        logic        act;
        logic [4:0]  sym;
        logic [12:0] qlen;
        bit          typed;
        logic [12:0] cnt;
        logic        ovf;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [sasu_pkg::IN_TDATA_W-1:0]  i_s_tdata;
    logic                             i_s_tuser;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [sasu_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    // Automaton mirror used to predict query answers.
    int unsigned sam_len [STATE_CAP];
    int unsigned sam_link[STATE_CAP];
    logic [13:0] sam_next[STATE_CAP][LETTERS];
    int unsigned sam_states;
    int unsigned sam_last;
    int unsigned text_len;
    logic [13:0] len_hist[TEXT_CAP + 2];
    logic        ovf_flag;

    logic [13:0] count_q[$];  // {overflow_seen, distinct_count}
    int          errors;

    suffix_automaton_substring_histogram_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned add_state(int unsigned len, int unsigned lnk);
        int unsigned idx;
        idx = sam_states;
        sam_states++;
        sam_len[idx]  = len;
        sam_link[idx] = lnk;
        for (int i = 0; i < LETTERS; i++) sam_next[idx][i] = '0;
        return idx;
    endfunction

    function automatic void reset_automaton();
        for (int i = 0; i < TEXT_CAP + 2; i++) len_hist[i] = '0;
        sam_states = 0;
        void'(add_state(0, 0));
        sam_last = 0;
        text_len = 0;
        ovf_flag = 1'b0;
    endfunction

    function automatic void extend_text(int unsigned c);
        int unsigned cur, p, q, cl, lo, hi;
        bit hit;
        cur = add_state(sam_len[sam_last] + 1, 0);
        p = sam_last;
        hit = 0;
        forever begin
            if (sam_next[p][c] != 0) begin
                hit = 1;
                break;
            end
            sam_next[p][c] = cur;
            if (p == 0) break;
            p = sam_link[p];
        end
        if (hit) begin
            q = sam_next[p][c];
            if (sam_len[p] + 1 == sam_len[q]) begin
                sam_link[cur] = q;
            end else begin
                cl = add_state(sam_len[p] + 1, sam_link[q]);
                for (int i = 0; i < LETTERS; i++) sam_next[cl][i] = sam_next[q][i];
                forever begin
                    if (sam_next[p][c] != q) break;
                    sam_next[p][c] = cl;
                    if (p == 0) break;
                    p = sam_link[p];
                end
                sam_link[q]   = cl;
                sam_link[cur] = cl;
            end
        end
        lo = sam_len[sam_link[cur]] + 1;
        hi = sam_len[cur] + 1;
        len_hist[lo] = len_hist[lo] + 14'd1;
        len_hist[hi] = len_hist[hi] - 14'd1;
        sam_last = cur;
        text_len++;
    endfunction

    // Returns {overflow_seen, distinct_count} for a query of length k.
    function automatic logic [13:0] distinct_of_length(int unsigned k);
        logic [13:0] sum;
        sum = '0;
        if (k != 0 && k <= text_len)
            for (int i = 0; i <= k; i++) sum = sum + len_hist[i];
        return {ovf_flag, sum[12:0]};
    endfunction

    function automatic void apply_item(logic act, logic [4:0] sym, logic [12:0] qlen);
        if (act == sasu_pkg::ACT_APPEND) begin
            if (text_len >= TEXT_CAP) ovf_flag = 1'b1;
            else if (sym < LETTERS) extend_text(sym);
        end else begin
            count_q.push_back(distinct_of_length(qlen));
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 12) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic act, logic [4:0] sym, logic [12:0] qlen, bit burst);
        int unsigned gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = act;
        i_s_tdata  = {6'd0, qlen, sym};
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic send_predicted(logic act, logic [4:0] sym, logic [12:0] qlen, bit burst);
        send_item(act, sym, qlen, burst);
        apply_item(act, sym, qlen);
    endtask

    // Query lengths are mostly short so that histogram walks stay cheap.
    function automatic logic [12:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(0, 24));
        if (r < 85) return 13'(text_len + $urandom_range(0, 1));
        if (r < 93) return 13'($urandom_range(0, 8191));
        return 13'($urandom_range(0, (text_len < 200) ? text_len : 200));
    endfunction

    // Receiver: random back-pressure with runs of no stalls.
    initial begin
        int unsigned r;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            r = $urandom_range(0, 99);
            if (r < 60) i_m_tready = 1'b1;
            else if (r < 95) i_m_tready = 1'b0;
            else begin
                i_m_tready = 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge i_clk);
                i_m_tready = 1'b1;
                repeat ($urandom_range(20, 80)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        logic [13:0] want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (count_q.size() == 0) begin
                $display("%t: unexpected transaction, actual cnt=%0d ovf=%0d",
                         $realtime, o_m_tdata[12:0], o_m_tdata[13]);
                errors++;
            end else begin
                want = count_q.pop_front();
                if (o_m_tdata[12:0] !== want[12:0]) begin
                    $display("%t: distinct_count expected %0d actual %0d",
                             $realtime, want[12:0], o_m_tdata[12:0]);
                    errors++;
                end
                if (o_m_tdata[13] !== want[13]) begin
                    $display("%t: overflow_seen expected %0d actual %0d",
                             $realtime, want[13], o_m_tdata[13]);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        int unsigned n, alpha, letter, wait_cycles;
        errors     = 0;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = sasu_pkg::ACT_APPEND;
        i_s_tdata  = '0;
        reset_automaton();

        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd0,    1, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd8191, 1, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd1,    1, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd0,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd25, 13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd31, 13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd26, 13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd1,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd2,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd3,    0, 13'd0, 1'b0});
        // "abab..." style text forces a state to be cloned.
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd0,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd1,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd0,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd1,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_APPEND, 5'd1,  13'd0,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd2,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd4,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd7,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd0,  13'd8,    0, 13'd0, 1'b0});
        rows.push_back('{sasu_pkg::ACT_QUERY,  5'd31, 13'd4096, 0, 13'd0, 1'b0});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.act, row.sym, row.qlen, 0);
            if (row.typed) begin
                count_q.push_back({row.ovf, row.cnt});
            end else begin
                apply_item(row.act, row.sym, row.qlen);
            end
        end

        // Hold the sender off until every answer has come back.
        i_s_tvalid = 1'b0;
        while (count_q.size() != 0) @(negedge i_clk);

        // Random text over small alphabets, which makes cloning frequent.
        alpha = 2;
        for (n = 0; n < 900; n++) begin
            if ($urandom_range(0, 39) == 0) alpha = $urandom_range(1, 4);
            if ($urandom_range(0, 99) < 55) begin
                if ($urandom_range(0, 29) == 0) letter = $urandom_range(0, 31);
                else letter = (alpha == 4 && $urandom_range(0, 3) == 0) ?
                              $urandom_range(0, 25) : $urandom_range(0, alpha - 1);
                send_predicted(sasu_pkg::ACT_APPEND, 5'(letter),
                               13'($urandom_range(0, 8191)), 0);
            end else begin
                send_predicted(sasu_pkg::ACT_QUERY, 5'($urandom_range(0, 31)),
                               pick_length(), 0);
            end
        end

        // Fill to capacity, with a few checks on the way.
        while (text_len < TEXT_CAP) begin
            if ($urandom_range(0, 199) == 0)
                send_predicted(sasu_pkg::ACT_QUERY, 5'd0, 13'($urandom_range(1, 16)), 0);
            else
                send_predicted(sasu_pkg::ACT_APPEND, 5'($urandom_range(0, 2)), 13'd0,
                               $urandom_range(0, 3) != 0);
        end

        send_predicted(sasu_pkg::ACT_QUERY,  5'd0,  13'd4096, 0);
        send_predicted(sasu_pkg::ACT_APPEND, 5'd3,  13'd0,    0);
        send_predicted(sasu_pkg::ACT_QUERY,  5'd0,  13'd1,    0);
        send_predicted(sasu_pkg::ACT_APPEND, 5'd31, 13'd0,    0);
        send_predicted(sasu_pkg::ACT_QUERY,  5'd0,  13'd4096, 0);
        send_predicted(sasu_pkg::ACT_QUERY,  5'd0,  13'd4097, 0);
        send_predicted(sasu_pkg::ACT_QUERY,  5'd0,  13'd0,    0);
        for (n = 0; n < 20; n++)
            send_predicted(sasu_pkg::ACT_QUERY, 5'd0, 13'($urandom_range(1, 30)), 0);
        i_s_tvalid = 1'b0;

        wait_cycles = 0;
        while (count_q.size() != 0 && wait_cycles < 200000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        if (count_q.size() != 0) begin
            $display("%t: expected %0d more output transactions, actual none",
                     $realtime, count_q.size());
            errors++;
        end
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
